>>> rtl/rsc_pkg.sv
// shared types, constants and helper functions of the radix string converter
// no dependencies: first file to compile

package rsc_pkg;

    localparam int VALUE_W        = 32;
    localparam int MAX_OUT_DIGITS = 32;
    localparam int SYM_W          = 8;
    localparam int BASE_W         = 6;
    localparam int DIGIT_W        = 6;
    localparam int IDX_W          = $clog2(MAX_OUT_DIGITS);
    localparam int LEN_W          = $clog2(MAX_OUT_DIGITS + 1);
    localparam int CFG_W          = 6;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = 2;

    // divider: bits of quotient resolved per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // register map indexes
    localparam logic [REG_IDX_W-1:0] REG_SRC_BASE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TGT_BASE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OUT_LEN  = 2'd2;

    localparam logic [CFG_W-1:0] RST_SRC_BASE = 6'd16;
    localparam logic [CFG_W-1:0] RST_TGT_BASE = 6'd10;
    localparam logic [CFG_W-1:0] RST_OUT_LEN  = 6'd5;

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    localparam logic [SYM_W-1:0] CH_0 = 8'h30;
    localparam logic [SYM_W-1:0] CH_9 = 8'h39;
    localparam logic [SYM_W-1:0] CH_A = 8'h41;
    localparam logic [SYM_W-1:0] CH_Z = 8'h5A;
    localparam logic [DIGIT_W-1:0] DEC_TEN = 6'd10;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic                 bad;
        logic [DIGIT_W-1:0]   digit;
    } t_sym_dec;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [CFG_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN)      r = BASE_MIN;
        else if (b > BASE_MAX) r = BASE_MAX;
        else                   r = b;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] n);
        logic [LEN_W-1:0] r;
        if (n == '0)                                  r = LEN_W'(1);
        else if ({1'b0, n} > (CFG_W+1)'(MAX_OUT_DIGITS)) r = LEN_W'(MAX_OUT_DIGITS);
        else                                          r = LEN_W'(n);
        return r;
    endfunction

    function automatic t_sym_dec decode_sym(input logic [SYM_W-1:0] s);
        t_sym_dec r;
        r.bad   = 1'b0;
        r.digit = '0;
        if (s >= CH_0 && s <= CH_9)      r.digit = DIGIT_W'(s - CH_0);
        else if (s >= CH_A && s <= CH_Z) r.digit = DIGIT_W'(s - CH_A) + DEC_TEN;
        else                             r.bad = 1'b1;
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] r;
        if (d < DEC_TEN) r = CH_0 + SYM_W'(d);
        else             r = CH_A + SYM_W'(d - DEC_TEN);
        return r;
    endfunction

endpackage

>>> rtl/rsc_sym_if.sv
// input symbol channel: valid/ready plus symbol and last mark
// depends on rsc_pkg

interface rsc_sym_if import rsc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> rtl/rsc_dig_if.sv
// output digit channel: valid/ready plus symbol, last mark and error flag
// depends on rsc_pkg

interface rsc_dig_if import rsc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             out_last;
    logic             bad_symbol;

    modport source (output valid, output out_symbol, output out_last, output bad_symbol,
                    input ready);
    modport sink   (input valid, input out_symbol, input out_last, input bad_symbol,
                    output ready);
endinterface

>>> rtl/rsc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module rsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rsc_div.sv
// iterative restoring divider, value by base, several quotient bits per cycle
// depends on rsc_pkg

module rsc_div import rsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [BASE_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quotient,
    output logic [DIGIT_W-1:0] o_remainder
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]   r_quo, n_quo;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [BASE_W-1:0]    r_dvs, n_dvs;

    always_comb begin
        logic [DIGIT_W:0]   t;
        logic [VALUE_W-1:0] q;
        logic [DIGIT_W-1:0] rm;
        q  = r_quo;
        rm = r_rem;
        t  = '0;
        // a few dependent compare/subtract steps on a narrow remainder
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {rm, q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                t    = t - {1'b0, r_dvs};
                q[0] = 1'b1;
            end
            rm = t[DIGIT_W-1:0];
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = q;
            n_rem = rm;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> rtl/radix_string_converter_core.sv
// radix string converter top level: apb registers, symbol intake, digit sequencer
// depends on rsc_pkg, rsc_sym_if, rsc_dig_if, rsc_ram, rsc_div
//
//  channel   dir  handshake        payload
//  i_sym     in   valid/ready      symbol[7:0], last
//  o_dig     out  valid/ready      out_symbol[7:0], out_last, bad_symbol
//  apb       in   psel/penable     paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
//  a symbol without the last mark is folded into the accumulator (one 32x6 multiply-add)
//  a last symbol starts n = clamped out_len divisions in the shared divider
//  each output symbol then takes a ram read, then is presented until ready is high
//  during a conversion i_sym.ready stays low until the last digit goes
//  synchronous active-low reset restores the register defaults and clears accumulator and flag
//  a stalled output simply holds; the digit ram read data is held until the next read

module radix_string_converter_core import rsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // request channels
    rsc_sym_if.sink               i_sym,
    rsc_dig_if.source             o_dig
);

    // configuration registers
    logic [CFG_W-1:0] r_src_base;
    logic [CFG_W-1:0] r_tgt_base;
    logic [CFG_W-1:0] r_out_len;

    // sequencer state
    t_state             r_state, n_state;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_err, n_err;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]   r_len, n_len;

    // datapath signals
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 sym_acc;
    t_sym_dec             dec;
    logic [VALUE_W-1:0]   digit_val;
    logic [VALUE_W-1:0]   acc_next;
    logic [BASE_W-1:0]    src_base;
    logic [BASE_W-1:0]    tgt_base;

    logic                 div_start;
    logic [VALUE_W-1:0]   div_dividend;
    logic                 div_done;
    logic [VALUE_W-1:0]   div_quo;
    logic [DIGIT_W-1:0]   div_rem;

    logic                 ram_we;
    logic                 ram_re;
    logic [DIGIT_W-1:0]   ram_rdata;

    // ---------------------------------------------------------------
    // apb register file, no wait states
    // ---------------------------------------------------------------
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= RST_SRC_BASE;
            r_tgt_base <= RST_TGT_BASE;
            r_out_len  <= RST_OUT_LEN;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SRC_BASE: r_src_base <= pwdata[CFG_W-1:0];
                REG_TGT_BASE: r_tgt_base <= pwdata[CFG_W-1:0];
                REG_OUT_LEN:  r_out_len  <= pwdata[CFG_W-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_BASE: prdata = APB_DATA_W'(r_src_base);
            REG_TGT_BASE: prdata = APB_DATA_W'(r_tgt_base);
            REG_OUT_LEN:  prdata = APB_DATA_W'(r_out_len);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // symbol intake: decode and multiply-accumulate, wraps at 2^32
    // ---------------------------------------------------------------
    assign src_base  = clamp_base(r_src_base);
    assign tgt_base  = clamp_base(r_tgt_base);
    assign dec       = decode_sym(i_sym.symbol);
    // an invalid symbol counts as the all-ones digit
    assign digit_val = dec.bad ? '1 : VALUE_W'(dec.digit);
    assign acc_next  = VALUE_W'(r_acc * VALUE_W'(src_base)) + digit_val;

    // no request is taken while reset is held
    assign i_sym.ready = (r_state == S_IDLE) && i_rst_n;
    assign sym_acc     = i_sym.valid && i_sym.ready;

    // first division takes the fresh value, later ones the previous quotient
    assign div_dividend = (r_state == S_IDLE) ? acc_next : div_quo;

    // ---------------------------------------------------------------
    // sequencer: divide out digits lsb first into the ram, then read msb first
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_err     = r_err;
        n_idx     = r_idx;
        n_len     = r_len;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (sym_acc) begin
                    n_err = r_err | dec.bad;
                    if (i_sym.last) begin
                        // value goes to the divider, accumulator restarts
                        n_acc     = '0;
                        n_len     = clamp_len(r_out_len);
                        n_idx     = IDX_W'(clamp_len(r_out_len) - 1'b1);
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_acc = acc_next;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_RD;
                    end else begin
                        n_idx     = r_idx - 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    if (o_dig.out_last) begin
                        n_err   = 1'b0;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_err   <= 1'b0;
            r_idx   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_err   <= n_err;
            r_idx   <= n_idx;
            r_len   <= n_len;
        end
    end

    // ---------------------------------------------------------------
    // output side, payload straight from the held ram read data
    // ---------------------------------------------------------------
    assign o_dig.valid      = (r_state == S_OUT);
    assign o_dig.out_symbol = digit_char(ram_rdata);
    assign o_dig.out_last   = (r_idx == IDX_W'(r_len - 1'b1));
    assign o_dig.bad_symbol = r_err;

    // ---------------------------------------------------------------
    // shared divider and digit buffer
    // ---------------------------------------------------------------
    rsc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (tgt_base),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rsc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_OUT_DIGITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

endmodule

>>> verif/tb_radix_string_converter_core.sv
// self-checking testbench of the radix string converter: directed and random symbol numbers
// depends on rsc_pkg, rsc_sym_if, rsc_dig_if and radix_string_converter_core with its submodules

module tb_radix_string_converter_core import rsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 250;
    localparam int PHASE_ITEMS    = 40;
    localparam int MAX_GAP        = 19;
    localparam int LONG_HOLD      = 300;
    // idle stretch between phases, long enough to cover any tail of a conversion of 32 digits
    localparam int IDLE_GUARD     = 400;
    localparam int END_GUARD      = 400;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int REPORT_LIMIT   = 10;

    // one expected or observed digit request
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             bad;
    } t_digit_req;

    // predicts the digit requests of each number and checks them in order
    class radix_checker;
        logic [CFG_W-1:0]   src_base_reg;
        logic [CFG_W-1:0]   tgt_base_reg;
        logic [CFG_W-1:0]   out_len_reg;
        logic [VALUE_W-1:0] acc;
        logic               err_seen;
        t_digit_req         expected_digits[$];
        int                 mismatches;

        function new();
            src_base_reg = RST_SRC_BASE;
            tgt_base_reg = RST_TGT_BASE;
            out_len_reg  = RST_OUT_LEN;
            acc          = '0;
            err_seen     = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_SRC_BASE: src_base_reg = data[CFG_W-1:0];
                REG_TGT_BASE: tgt_base_reg = data[CFG_W-1:0];
                REG_OUT_LEN:  out_len_reg  = data[CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BASE_W-1:0] clip_radix(logic [CFG_W-1:0] r);
            if (r < BASE_MIN) begin
                return BASE_MIN;
            end
            if (r > BASE_MAX) begin
                return BASE_MAX;
            end
            return r;
        endfunction

        function logic [BASE_W-1:0] source_radix();
            return clip_radix(src_base_reg);
        endfunction

        function logic [SYM_W-1:0] ascii_digit(logic [DIGIT_W-1:0] d);
            return SYM_W'(d) + ((d < DEC_TEN) ? CH_0 : (CH_A - SYM_W'(DEC_TEN)));
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        // fold one accepted symbol request; a last one queues the whole output run
        function void fold_symbol(logic [SYM_W-1:0] sym, logic last);
            logic [VALUE_W-1:0] digit;
            logic [VALUE_W-1:0] rest;
            logic [VALUE_W-1:0] radix;
            logic [DIGIT_W-1:0] digits [MAX_OUT_DIGITS];
            int                 n;
            t_digit_req         d;
            if (sym >= CH_0 && sym <= CH_9) begin
                digit = VALUE_W'(sym - CH_0);
            end else if (sym >= CH_A && sym <= CH_Z) begin
                digit = VALUE_W'(sym - CH_A) + VALUE_W'(DEC_TEN);
            end else begin
                // invalid symbol folds in as all ones
                digit    = '1;
                err_seen = 1'b1;
            end
            acc = acc * VALUE_W'(clip_radix(src_base_reg)) + digit;
            if (!last) begin
                return;
            end
            radix = VALUE_W'(clip_radix(tgt_base_reg));
            if (out_len_reg == '0) begin
                n = 1;
            end else if (out_len_reg > MAX_OUT_DIGITS) begin
                n = MAX_OUT_DIGITS;
            end else begin
                n = int'(out_len_reg);
            end
            rest = acc;
            for (int i = n - 1; i >= 0; i--) begin
                digits[i] = DIGIT_W'(rest % radix);
                rest      = rest / radix;
            end
            for (int i = 0; i < n; i++) begin
                d.symbol = ascii_digit(digits[i]);
                d.last   = (i == n - 1);
                d.bad    = err_seen;
                expected_digits.push_back(d);
            end
            acc      = '0;
            err_seen = 1'b0;
        endfunction

        function void report(string what, t_digit_req want, t_digit_req got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t digit %s: expected sym=%h last=%b bad=%b, got sym=%h last=%b bad=%b",
                         $realtime, what, want.symbol, want.last, want.bad,
                         got.symbol, got.last, got.bad);
            end
        endfunction

        function void check_digit(logic [SYM_W-1:0] sym, logic last, logic bad);
            t_digit_req want;
            t_digit_req got;
            got.symbol = sym;
            got.last   = last;
            got.bad    = bad;
            if (expected_digits.size() == 0) begin
                report("unexpected", '0, got);
                return;
            end
            want = expected_digits.pop_front();
            if (want.symbol !== got.symbol || want.last !== got.last || want.bad !== got.bad) begin
                report("mismatch", want, got);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rsc_sym_if sym_if ();
    rsc_dig_if dig_if ();

    radix_string_converter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_sym   (sym_if),
        .o_dig   (dig_if)
    );

    radix_checker chk = new();

    // idling of each side per request, 0 means back to back
    int send_gap_max = 0;
    int stall_max    = 0;
    // set by the stimulus to make the digit sink hold off once for a long stretch
    bit long_hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor: values seen here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (dig_if.valid && dig_if.ready) begin
                chk.check_digit(dig_if.out_symbol, dig_if.out_last, dig_if.bad_symbol);
            end
            if (sym_if.valid && sym_if.ready) begin
                chk.fold_symbol(sym_if.symbol, sym_if.last);
            end
        end
    end

    // digit sink: random stall before every digit request, one long hold on demand
    initial begin : digit_sink
        int wait_cycles;
        dig_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                wait_cycles   = LONG_HOLD;
            end else begin
                wait_cycles = $urandom_range(0, stall_max);
            end
            if (wait_cycles > 0) begin
                dig_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            dig_if.ready <= 1'b1;
            do @(posedge i_clk); while (!dig_if.valid);
        end
    end

    // register write: setup cycle, access cycle, then the bus idles before the task returns
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic [APB_DATA_W-1:0] data;
        data            = $urandom;
        data[CFG_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chk.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] src, input logic [CFG_W-1:0] tgt,
                             input logic [CFG_W-1:0] len);
        apb_write(REG_SRC_BASE, src);
        apb_write(REG_TGT_BASE, tgt);
        apb_write(REG_OUT_LEN, len);
    endtask

    // offer one symbol request after a random gap and hold it until taken
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sym_if.valid  <= 1'b1;
        sym_if.symbol <= sym;
        sym_if.last   <= last;
        do @(posedge i_clk); while (!sym_if.ready);
    endtask

    // whole number packed most significant symbol first, last mark on the final one
    task automatic send_word(input logic [63:0] word, input int count);
        for (int i = 0; i < count; i++) begin
            send_symbol(word[8*(count-1-i) +: 8], i == count - 1);
        end
    endtask

    // stop offering and wait until every predicted digit has come out
    task automatic wait_drained();
        sym_if.valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(input int radix);
        int p;
        p = $urandom_range(0, 99);
        if (p < 80) begin
            return chk.ascii_digit(DIGIT_W'($urandom_range(0, radix - 1)));
        end
        // a valid symbol that may be at or above the base
        if (p < 90) begin
            return chk.ascii_digit(DIGIT_W'($urandom_range(0, 35)));
        end
        return SYM_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_W-1:0] pick_radix();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0:       return CFG_W'($urandom_range(0, 1));
            1:       return CFG_W'($urandom_range(37, 63));
            2:       return BASE_MIN;
            3:       return BASE_MAX;
            default: return CFG_W'($urandom_range(2, 36));
        endcase
    endfunction

    // mostly short runs, the odd full or out of range length
    function automatic logic [CFG_W-1:0] pick_out_len();
        int p;
        p = $urandom_range(0, 11);
        case (p)
            0:       return '0;
            1:       return CFG_W'($urandom_range(33, 63));
            2:       return CFG_W'(MAX_OUT_DIGITS);
            3:       return CFG_W'(1);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin : stimulus
        int random_items;
        int phase;
        int phase_items;
        int count;
        int len;
        int radix;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        sym_if.valid  <= 1'b0;
        sym_if.symbol <= '0;
        sym_if.last   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, first at the reset settings
        send_gap_max = MAX_GAP;
        stall_max    = MAX_GAP;
        send_word("FF", 2);
        // lowest symbol code is invalid
        send_word(64'h00, 1);
        // highest code invalid, then a digit above base sixteen
        send_word({8'hFF, "Z"}, 2);

        // base above range, base below range, longest run: accumulator wraps
        wait_drained();
        repeat (IDLE_GUARD) @(posedge i_clk);
        configure(6'd63, 6'd0, CFG_W'(MAX_OUT_DIGITS));
        send_word("ZZZZZZZ", 7);

        // base zero, base at the top of the field, zero length
        wait_drained();
        repeat (IDLE_GUARD) @(posedge i_clk);
        configure(6'd0, 6'd63, 6'd0);
        send_word("101", 3);
        send_word("@", 1);
        send_word("[", 1);

        // base one on both sides, length above the digit store
        wait_drained();
        repeat (IDLE_GUARD) @(posedge i_clk);
        configure(6'd1, 6'd1, 6'd63);
        send_word("/:", 2);

        // both bases at their maximum, single digit
        wait_drained();
        repeat (IDLE_GUARD) @(posedge i_clk);
        configure(BASE_MAX, BASE_MAX, 6'd1);
        send_word("9A", 2);
        send_word("a", 1);

        // random phases, each with its own settings and idling pattern
        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_drained();
            repeat (IDLE_GUARD) @(posedge i_clk);
            configure(pick_radix(), pick_radix(), pick_out_len());
            case (phase % 4)
                0: begin
                    send_gap_max = MAX_GAP;
                    stall_max    = MAX_GAP;
                end
                1: begin
                    send_gap_max = 0;
                    stall_max    = 0;
                end
                2: begin
                    send_gap_max = 0;
                    stall_max    = MAX_GAP;
                end
                default: begin
                    send_gap_max = MAX_GAP;
                    stall_max    = 0;
                end
            endcase
            // sink holds off while symbols keep coming, so the block backs up
            if (phase == 1) begin
                long_hold_req = 1'b1;
            end
            phase_items = 0;
            count       = 0;
            while (phase_items < PHASE_ITEMS) begin
                // sender pauses once per phase until every digit request is out
                if (count == 2) begin
                    wait_drained();
                end
                len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                     : $urandom_range(7, 12);
                radix = int'(chk.source_radix());
                for (int j = 0; j < len; j++) begin
                    send_symbol(pick_symbol(radix), j == len - 1);
                end
                phase_items += len;
                count++;
            end
            random_items += phase_items;
            phase++;
        end

        wait_drained();
        repeat (END_GUARD) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rsc_pkg.sv
rtl/rsc_sym_if.sv
rtl/rsc_dig_if.sv
rtl/rsc_ram.sv
rtl/rsc_div.sv
rtl/radix_string_converter_core.sv
verif/tb_radix_string_converter_core.sv
